FILE: design/psrb_pkg.sv
`default_nettype none

package psrb_pkg;

	localparam int unsigned SPOOL_DEPTH_DEF = 64;

	localparam logic [7:0] READY_BYTE = 8'hFF;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_DRAIN = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	localparam logic [3:0] OFF_DATA_A = 4'd0;
	localparam logic [3:0] OFF_DATA_B = 4'd1;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic calc_abs;
		logic calc_start;
		logic start_read;
		logic next_read;
		logic load_out;
		logic out_byte;
	} psrb_cmd_t;

	typedef struct packed {
		logic empty;
		logic last_byte;
		logic out_free;
	} psrb_stat_t;

endpackage

`default_nettype wire

FILE: design/psrb_ctrl.sv
`default_nettype none

module psrb_ctrl
	import psrb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] kind,
	input  wire psrb_stat_t stat,
	output psrb_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_ABS   = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_FETCH = 3'd4;
	localparam logic [2:0] S_SEND  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_nx     = (kind == KIND_DRAIN) ? S_ABS : S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec     = 1'b1;
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			S_ABS: begin
				cmd.calc_abs = 1'b1;
				state_nx     = S_START;
			end
			S_START: begin
				cmd.calc_start = 1'b1;
				state_nx       = S_FETCH;
			end
			S_FETCH: begin
				if (stat.empty) begin
					state_nx = S_EXEC;
				end else begin
					cmd.start_read = 1'b1;
					state_nx       = S_SEND;
				end
			end
			S_SEND: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_byte = 1'b1;
					if (stat.last_byte) begin
						state_nx = S_IDLE;
					end else begin
						cmd.next_read = 1'b1;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

`ifndef SYNTHESIS
	a_load_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded while the output register is occupied");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("controller idle after accepting a transaction");

	a_single_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.exec, cmd.calc_abs, cmd.calc_start, cmd.start_read, cmd.latch_in}))
		else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

FILE: design/psrb_dp.sv
`default_nettype none

module psrb_dp
	import psrb_pkg::*;
#(
	parameter int unsigned SPOOL_DEPTH = SPOOL_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire psrb_cmd_t   cmd,
	output psrb_stat_t       stat,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  offset,
	input  wire logic [7:0]  wdata,
	input  wire logic [31:0] cursor,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       byte_out,
	output logic             byte_valid,
	output logic             last,
	output logic [31:0]      total_count,
	output logic             truncated
);

	localparam int unsigned PTR_W = $clog2(SPOOL_DEPTH);
	localparam int unsigned CNT_W = $clog2(SPOOL_DEPTH + 1);
	localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(SPOOL_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(SPOOL_DEPTH);

	function automatic logic [PTR_W-1:0] ring_wrap(input logic [PTR_W:0] s);
		logic [PTR_W:0] t;
		t = s - DEPTH_P;
		if (s >= DEPTH_P) begin
			ring_wrap = t[PTR_W-1:0];
		end else begin
			ring_wrap = s[PTR_W-1:0];
		end
	endfunction

	logic [7:0] mem [SPOOL_DEPTH];

	logic [1:0]       kind_q;
	logic [3:0]       offset_q;
	logic [7:0]       wdata_q;
	logic [31:0]      cursor_q;
	logic [31:0]      base_q;
	logic [31:0]      total_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [31:0]      abs_q;
	logic [CNT_W-1:0] start_q;
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       rd_q;

	logic             out_valid_q;
	logic [7:0]       byte_q;
	logic             bvalid_q;
	logic             last_q;
	logic [31:0]      total_out_q;
	logic             trunc_q;

	logic [31:0]      base_nx;
	logic [31:0]      total_nx;
	logic [PTR_W-1:0] head_nx;
	logic [CNT_W-1:0] fill_nx;
	logic             spool_we;
	logic             full;
	logic [PTR_W-1:0] wr_addr;
	logic [PTR_W-1:0] pos_start;
	logic [PTR_W-1:0] rd_addr;
	logic             rd_en;
	logic [31:0]      diff;

	assign full      = (fill_q == DEPTH_C);
	assign wr_addr   = full ? head_q : ring_wrap({1'b0, head_q} + {1'b0, fill_q[PTR_W-1:0]});
	assign pos_start = ring_wrap({1'b0, head_q} + {1'b0, start_q[PTR_W-1:0]});
	assign rd_addr   = cmd.start_read ? pos_start : pos_q;
	assign rd_en     = cmd.start_read | cmd.next_read;
	assign diff      = abs_q - base_q;

	assign stat.empty     = (start_q == fill_q);
	assign stat.last_byte = (cnt_q == CNT_W'(1));
	assign stat.out_free  = !out_valid_q || !out_stall;

	always_comb begin
		base_nx  = base_q;
		total_nx = total_q;
		head_nx  = head_q;
		fill_nx  = fill_q;
		spool_we = 1'b0;
		if (cmd.exec) begin
			case (kind_q)
				KIND_WRITE: begin
					if (offset_q inside {OFF_DATA_A, OFF_DATA_B}) begin
						spool_we = 1'b1;
						total_nx = total_q + 32'd1;
						if (full) begin
							base_nx = base_q + 32'd1;
							head_nx = ring_wrap({1'b0, head_q} + (PTR_W + 1)'(1));
						end else begin
							fill_nx = fill_q + CNT_W'(1);
						end
					end
				end
				KIND_CLEAR: begin
					base_nx  = '0;
					total_nx = '0;
					head_nx  = '0;
					fill_nx  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (spool_we) begin
			mem[wr_addr] <= wdata_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q   <= kind;
			offset_q <= offset;
			wdata_q  <= wdata;
			cursor_q <= cursor;
		end
		if (cmd.calc_abs) begin
			if (cursor_q > total_q) begin
				abs_q <= base_q;
			end else begin
				abs_q <= (cursor_q > base_q) ? cursor_q : base_q;
			end
		end
		if (cmd.calc_start) begin
			start_q <= (diff > 32'(fill_q)) ? fill_q : diff[CNT_W-1:0];
		end
		if (cmd.start_read) begin
			pos_q <= ring_wrap({1'b0, pos_start} + (PTR_W + 1)'(1));
			cnt_q <= fill_q - start_q;
		end else if (cmd.next_read) begin
			pos_q <= ring_wrap({1'b0, pos_q} + (PTR_W + 1)'(1));
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.load_out) begin
			byte_q      <= cmd.out_byte ? rd_q : 8'd0;
			bvalid_q    <= cmd.out_byte;
			last_q      <= cmd.out_byte ? (cnt_q == CNT_W'(1)) : 1'b1;
			total_out_q <= total_nx;
			trunc_q     <= (base_nx != 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			total_q     <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			base_q  <= base_nx;
			total_q <= total_nx;
			head_q  <= head_nx;
			fill_q  <= fill_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign byte_out    = byte_q;
	assign byte_valid  = bvalid_q;
	assign last        = last_q;
	assign total_count = total_out_q;
	assign truncated   = trunc_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_C)
		else $error("spool fill level beyond its depth");

	a_fill_matches_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q - base_q) == 32'(fill_q))
		else $error("fill level disagrees with the index counters");

	a_next_read_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_read |-> (cnt_q > CNT_W'(1)))
		else $error("spool read past the newest byte");
`endif

endmodule

`default_nettype wire

FILE: design/printer_spool_ring_buffer_core.sv
`default_nettype none

// Printer port capture spool: bus writes to offset 0 or 1 append their byte to a ring of
// SPOOL_DEPTH bytes, evicting the oldest byte once the ring is full, and a bus read always
// answers 0xFF. A read, write or clear transaction is accepted while the controller is idle and
// its single result is loaded into the output register on the next cycle in which that register
// is free. A drain works out its starting point in three steps (cursor against the counters,
// offset into the ring, first memory read) and then streams one byte per cycle, paced by the
// registered read of the spool memory and by stalls on the output, or gives one result with no
// byte when nothing is left to send. No new transaction is accepted until the final result of
// the last one has been loaded. A spool entry is only ever read after it has been written since
// the last clear, so the memory needs no clearing after reset.
module printer_spool_ring_buffer_core
	import psrb_pkg::*;
#(
	parameter int unsigned SPOOL_DEPTH = SPOOL_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  offset,
	input  wire logic [7:0]  wdata,
	input  wire logic [31:0] cursor,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       rdata,
	output logic [7:0]       byte_out,
	output logic             byte_valid,
	output logic             last,
	output logic [31:0]      total_count,
	output logic             truncated
);

	psrb_cmd_t  cmd;
	psrb_stat_t stat;

	assign rdata = READY_BYTE;

	psrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.stat     (stat),
		.cmd      (cmd)
	);

	psrb_dp #(
		.SPOOL_DEPTH (SPOOL_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.offset      (offset),
		.wdata       (wdata),
		.cursor      (cursor),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.byte_out    (byte_out),
		.byte_valid  (byte_valid),
		.last        (last),
		.total_count (total_count),
		.truncated   (truncated)
	);

endmodule

`default_nettype wire

FILE: bench/spool_checker.sv
module spool_checker
	import psrb_pkg::*;
#(
	parameter int unsigned DEPTH = SPOOL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [3:0]        offset,
	input  logic [7:0]        wdata,
	input  logic [31:0]       cursor,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [7:0]        rdata,
	input  logic [7:0]        byte_out,
	input  logic              byte_valid,
	input  logic              last,
	input  logic [31:0]       total_count,
	input  logic              truncated,
	output int unsigned       mismatches,
	output int unsigned       outstanding
);

	localparam int unsigned DUE_SLOTS = 256;

	typedef struct packed {
		logic [7:0]  rdata;
		logic [7:0]  byte_out;
		logic        byte_valid;
		logic        last;
		logic [31:0] total_count;
		logic        truncated;
	} spool_result_t;

	spool_result_t due_ring [DUE_SLOTS];
	int unsigned   due_wr;
	int unsigned   due_rd;
	logic [7:0]    spool_mem [DEPTH];
	logic [31:0]   oldest_idx;
	logic [31:0]   written_idx;
	int unsigned   ring_head;
	int unsigned   error_count;

	function automatic int unsigned held_bytes();
		logic [31:0] n;
		n = written_idx - oldest_idx;
		return (n > DEPTH) ? DEPTH : n;
	endfunction

	function automatic void queue_result(logic [7:0] b, logic valid, logic fin);
		spool_result_t r;
		r.rdata       = READY_BYTE;
		r.byte_out    = b;
		r.byte_valid  = valid;
		r.last        = fin;
		r.total_count = written_idx;
		r.truncated   = (oldest_idx != 0);
		due_ring[due_wr % DUE_SLOTS] = r;
		due_wr = due_wr + 1;
	endfunction

	// Every accepted transaction queues the results it causes; writes and clears also update the spool image.
	function automatic void spool_response(logic [1:0] k, logic [3:0] o, logic [7:0] w,
			logic [31:0] c);
		int unsigned n;
		int unsigned start;
		logic [31:0] first;
		case (k)
		KIND_WRITE: begin
			if (o == OFF_DATA_A || o == OFF_DATA_B) begin
				n = held_bytes();
				if (n == DEPTH) begin
					ring_head  = (ring_head + 1) % DEPTH;
					oldest_idx = oldest_idx + 1;
					n = n - 1;
				end
				spool_mem[(ring_head + n) % DEPTH] = w;
				written_idx = written_idx + 1;
			end
			queue_result(8'h00, 1'b0, 1'b1);
		end
		KIND_CLEAR: begin
			oldest_idx  = '0;
			written_idx = '0;
			ring_head   = 0;
			queue_result(8'h00, 1'b0, 1'b1);
		end
		KIND_DRAIN: begin
			n = held_bytes();
			if (c > written_idx) begin
				first = oldest_idx;
			end else begin
				first = (c > oldest_idx) ? c : oldest_idx;
			end
			start = first - oldest_idx;
			if (start > n)
				start = n;
			if (start == n) begin
				queue_result(8'h00, 1'b0, 1'b1);
			end else begin
				for (int unsigned i = start; i < n; i++)
					queue_result(spool_mem[(ring_head + i) % DEPTH], 1'b1, (i + 1 == n));
			end
		end
		default: begin
			queue_result(8'h00, 1'b0, 1'b1);
		end
		endcase
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		spool_result_t want;
		if (!arst_n) begin
			due_wr      = 0;
			due_rd      = 0;
			oldest_idx  = '0;
			written_idx = '0;
			ring_head   = 0;
			error_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_wr == due_rd) begin
					$display("%0t: unexpected result transaction, expected none, actual byte %0h last %0b",
						$time, byte_out, last);
					error_count++;
				end else begin
					want = due_ring[due_rd % DUE_SLOTS];
					due_rd = due_rd + 1;
					compare_field("rdata", want.rdata, rdata);
					compare_field("byte_out", want.byte_out, byte_out);
					compare_field("byte_valid", want.byte_valid, byte_valid);
					compare_field("last", want.last, last);
					compare_field("total_count", want.total_count, total_count);
					compare_field("truncated", want.truncated, truncated);
				end
			end
			if (in_valid && !in_stall)
				spool_response(kind, offset, wdata, cursor);
		end
		outstanding <= due_wr - due_rd;
		mismatches  <= error_count;
	end

endmodule

FILE: bench/testbench.sv
module testbench;
	import psrb_pkg::*;

	localparam int unsigned ITEM_TARGET   = 380;
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 20;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [1:0]  kind      = KIND_READ;
	logic [3:0]  offset    = '0;
	logic [7:0]  wdata     = '0;
	logic [31:0] cursor    = '0;
	logic        out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [7:0]  rdata;
	logic [7:0]  byte_out;
	logic        byte_valid;
	logic        last;
	logic [31:0] total_count;
	logic        truncated;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	int unsigned stall_left  = 0;
	int unsigned stall_roll;
	int unsigned stall_mode  = 1;
	int unsigned gap_mode    = 0;
	int unsigned items_sent  = 0;
	logic [31:0] spooled     = '0;

	always #1 clk = ~clk;

	printer_spool_ring_buffer_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.offset      (offset),
		.wdata       (wdata),
		.cursor      (cursor),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rdata       (rdata),
		.byte_out    (byte_out),
		.byte_valid  (byte_valid),
		.last        (last),
		.total_count (total_count),
		.truncated   (truncated)
	);

	spool_checker spool_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.offset      (offset),
		.wdata       (wdata),
		.cursor      (cursor),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rdata       (rdata),
		.byte_out    (byte_out),
		.byte_valid  (byte_valid),
		.last        (last),
		.total_count (total_count),
		.truncated   (truncated),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall pattern: mode zero gives stretches with no stalls.
	always @(posedge clk) begin
		if (cycle_count % 256 == 0)
			stall_mode <= $urandom_range(0, 2);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			stall_roll = $urandom_range(0, 99);
			if (stall_mode == 0 || stall_roll < 55) begin
				out_stall  <= 1'b0;
				stall_left <= $urandom_range(0, 6);
			end else if (stall_roll < 94) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(5, 24);
			end
		end
	end

	task automatic send(input logic [1:0] k, input logic [3:0] o, input logic [7:0] w,
			input logic [31:0] c);
		int unsigned gap;
		in_valid <= 1'b1;
		kind     <= k;
		offset   <= o;
		wdata    <= w;
		cursor   <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		if (k == KIND_CLEAR)
			spooled = '0;
		else if (k == KIND_WRITE && (o == OFF_DATA_A || o == OFF_DATA_B))
			spooled = spooled + 1;
		case (gap_mode)
		0: gap = 0;
		1: gap = $urandom_range(0, 2);
		default: gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
		endcase
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned burst;
		logic [31:0] cursor_pick;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(KIND_READ, 4'd0, 8'h00, 32'h0);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'h0);
		send(KIND_WRITE, OFF_DATA_A, 8'h00, 32'h0);
		send(KIND_WRITE, OFF_DATA_B, 8'hFF, 32'hFFFF_FFFF);
		send(KIND_WRITE, 4'd15, 8'hAA, 32'h0);
		send(KIND_WRITE, 4'd7, 8'h55, 32'h0);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'd0);
		send(KIND_DRAIN, 4'd15, 8'hFF, 32'd1);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'd2);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'hFFFF_FFFF);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'd3);
		send(KIND_READ, 4'd15, 8'hFF, 32'hFFFF_FFFF);
		send(KIND_CLEAR, 4'd0, 8'h00, 32'h0);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'd0);
		send(KIND_READ, 4'd5, 8'h00, 32'h0);
		send(KIND_WRITE, OFF_DATA_B, 8'h5A, 32'h0);
		send(KIND_DRAIN, 4'd0, 8'h00, 32'd0);
		send(KIND_CLEAR, 4'd15, 8'hFF, 32'hFFFF_FFFF);

		while (items_sent < ITEM_TARGET) begin
			gap_mode = $urandom_range(0, 3);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				burst = ($urandom_range(0, 11) == 0) ? $urandom_range(40, 72) : $urandom_range(1, 12);
				if (burst > ITEM_TARGET - items_sent)
					burst = ITEM_TARGET - items_sent;
				repeat (burst)
					send(KIND_WRITE, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), $urandom);
			end else if (pick < 77) begin
				case ($urandom_range(0, 5))
				0: cursor_pick = spooled - $urandom_range(0, 8);
				1: cursor_pick = spooled - $urandom_range(0, 80);
				2: cursor_pick = spooled;
				3: cursor_pick = spooled + $urandom_range(1, 3);
				4: cursor_pick = $urandom;
				default: cursor_pick = '0;
				endcase
				send(KIND_DRAIN, 4'($urandom), 8'($urandom), cursor_pick);
			end else if (pick < 90) begin
				send(KIND_READ, 4'($urandom), 8'($urandom), $urandom);
			end else if (pick < 95) begin
				send(KIND_CLEAR, 4'($urandom), 8'($urandom), $urandom);
			end else begin
				send(KIND_WRITE, 4'($urandom_range(2, 15)), 8'($urandom), $urandom);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
